>>> hw/rtl/cpdi_pkg.sv
`timescale 1ns / 1ps
// Package: request/response types, opcodes, register indexes and FSM states.
package cpdi_pkg;

   // Request opcodes
   typedef enum logic [1:0] {
      OP_BEGIN = 2'd0,
      OP_EDGE  = 2'd1,
      OP_END   = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   // Response kinds
   typedef enum logic [1:0] {
      KIND_COUNT   = 2'd0,
      KIND_ELEMENT = 2'd1,
      KIND_EMPTY   = 2'd2
   } kind_type;

   // Register indexes
   localparam logic [1:0] CSR_COLUMN_SELECT = 2'd0;
   localparam logic [1:0] CSR_END_MODE      = 2'd1;

   typedef struct packed {
      op_type      op;
      logic [11:0] vertex_a;
      logic [11:0] vertex_b;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [11:0] element;
      logic [12:0] kept_total;
      logic        last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SCAN,
      ST_ISECT,
      ST_RD_DATA,
      ST_EMIT
   } state_type;

endpackage

>>> hw/rtl/column_projection_distinct_intersect_unit.sv
`timescale 1ns / 1ps
// Column projection with bitmap duplicate elimination and kept-list intersection.
// Edge requests: accepted back to back while idle (one bitmap write per cycle).
// Begin: clear pass over all D = min(MAX_VERTICES, 4096) bitmap entries, one entry a cycle.
// End, replace: scans the bitmap in ascending order; intersect: compacts the kept list
// through the read -> bitmap read -> write pipeline; then emits once the output is free.
// Read: one kept-list memory read while entries remain. Reset clears control state, then runs
// the bitmap clear pass over D entries with req_ready low; the csr port stays open.
module column_projection_distinct_intersect_unit #(
   parameter int MAX_VERTICES = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cpdi_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output cpdi_pkg::rsp_type     rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic                  csr_wdata
);

   // Vertex ids are 12 bits, so no more than 4096 bitmap entries can ever be set
   localparam int DEPTH = (MAX_VERTICES < 4096) ? MAX_VERTICES : 4096;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [12:0]   DEPTH_W = 13'(DEPTH);

   // Memories
   logic             bitmap_mem [DEPTH];
   logic [11:0]      kept_mem   [DEPTH];

   logic             bm_we, bm_wdata, bm_re;
   logic [AW-1:0]    bm_waddr, bm_raddr;
   logic             bm_rdata_ff;
   logic             kp_we, kp_re;
   logic [AW-1:0]    kp_waddr, kp_raddr;
   logic [11:0]      kp_wdata;
   logic [11:0]      kp_rdata_ff;

   // Control and datapath registers
   cpdi_pkg::state_type state_ff, state_in;
   logic [CW-1:0]    idx_ff, idx_in;
   logic [CW-1:0]    n_ff, n_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    rp_ff, rp_in;
   logic             s1_ff, s1_in;
   logic [AW-1:0]    s1_addr_ff, s1_addr_in;
   logic             p1_ff, p1_in;
   logic             p2_ff, p2_in;
   logic [11:0]      p2_c_ff, p2_c_in;
   logic             p2_ok_ff, p2_ok_in;
   cpdi_pkg::rsp_type res_ff, res_in;
   cpdi_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             column_select_ff, column_select_in;
   logic             end_mode_ff, end_mode_in;

   logic             req_fire, rsp_free, csr_fire;
   logic             scan_issue, isect_issue, clear_last, rd_hit;
   logic [11:0]      edge_v;
   logic             c_ok;

   assign req_ready = (state_ff == cpdi_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign scan_issue  = (idx_ff < DEPTH_C);
   assign isect_issue = (idx_ff < count_ff);
   assign clear_last  = (idx_ff == DEPTH_C - CW'(1));
   assign rd_hit      = (rp_ff < count_ff);
   assign edge_v      = column_select_ff ? req_data.vertex_b : req_data.vertex_a;
   assign c_ok        = ({1'b0, kp_rdata_ff} < DEPTH_W);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cpdi_pkg::ST_IDLE: begin
            if (req_fire) begin
               unique case (req_data.op)
                  cpdi_pkg::OP_BEGIN: state_in = cpdi_pkg::ST_CLEAR;
                  cpdi_pkg::OP_EDGE:  state_in = cpdi_pkg::ST_IDLE;
                  cpdi_pkg::OP_END:   state_in = end_mode_ff ? cpdi_pkg::ST_ISECT
                                                             : cpdi_pkg::ST_SCAN;
                  cpdi_pkg::OP_READ:  state_in = rd_hit ? cpdi_pkg::ST_RD_DATA
                                                        : cpdi_pkg::ST_EMIT;
                  default:            state_in = cpdi_pkg::ST_IDLE;
               endcase
            end
         end
         cpdi_pkg::ST_CLEAR: begin
            if (clear_last) state_in = cpdi_pkg::ST_IDLE;
         end
         cpdi_pkg::ST_SCAN: begin
            if (!scan_issue && !s1_ff) state_in = cpdi_pkg::ST_EMIT;
         end
         cpdi_pkg::ST_ISECT: begin
            if (!isect_issue && !p1_ff && !p2_ff) state_in = cpdi_pkg::ST_EMIT;
         end
         cpdi_pkg::ST_RD_DATA: state_in = cpdi_pkg::ST_EMIT;
         cpdi_pkg::ST_EMIT: begin
            if (rsp_free) state_in = cpdi_pkg::ST_IDLE;
         end
         default: state_in = cpdi_pkg::ST_IDLE;
      endcase
   end

   // Datapath, memory ports and response
   always_comb begin
      idx_in       = idx_ff;
      n_in         = n_ff;
      count_in     = count_ff;
      rp_in        = rp_ff;
      s1_in        = 1'b0;
      s1_addr_in   = s1_addr_ff;
      p1_in        = 1'b0;
      p2_in        = 1'b0;
      p2_c_in      = p2_c_ff;
      p2_ok_in     = p2_ok_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      bm_we        = 1'b0;
      bm_waddr     = idx_ff[AW-1:0];
      bm_wdata     = 1'b0;
      bm_re        = 1'b0;
      bm_raddr     = idx_ff[AW-1:0];
      kp_we        = 1'b0;
      kp_waddr     = n_ff[AW-1:0];
      kp_wdata     = 12'(s1_addr_ff);
      kp_re        = 1'b0;
      kp_raddr     = idx_ff[AW-1:0];

      unique case (state_ff)
         cpdi_pkg::ST_IDLE: begin
            if (req_fire) begin
               idx_in = '0;
               n_in   = '0;
               unique case (req_data.op)
                  cpdi_pkg::OP_EDGE: begin
                     // mark the projected vertex, drop ids beyond the bitmap
                     bm_we    = ({1'b0, edge_v} < DEPTH_W);
                     bm_waddr = edge_v[AW-1:0];
                     bm_wdata = 1'b1;
                  end
                  cpdi_pkg::OP_READ: begin
                     kp_re    = rd_hit;
                     kp_raddr = rp_ff[AW-1:0];
                     res_in   = '{kind: cpdi_pkg::KIND_EMPTY, element: '0,
                                  kept_total: '0, last: 1'b0};
                  end
                  default: ;
               endcase
            end
         end
         cpdi_pkg::ST_CLEAR: begin
            // sweep zeros through the bitmap
            bm_we  = 1'b1;
            idx_in = clear_last ? '0 : idx_ff + CW'(1);
         end
         cpdi_pkg::ST_SCAN: begin
            // read bitmap in ascending order, append set positions
            bm_re      = scan_issue;
            s1_in      = scan_issue;
            s1_addr_in = idx_ff[AW-1:0];
            if (scan_issue) idx_in = idx_ff + CW'(1);
            if (s1_ff && bm_rdata_ff) begin
               kp_we = 1'b1;
               n_in  = n_ff + CW'(1);
            end
            if (!scan_issue && !s1_ff) begin
               count_in = n_ff;
               rp_in    = '0;
               res_in   = '{kind: cpdi_pkg::KIND_COUNT, element: '0,
                            kept_total: 13'(n_ff), last: 1'b0};
            end
         end
         cpdi_pkg::ST_ISECT: begin
            // stage 0: read kept entry
            kp_re = isect_issue;
            p1_in = isect_issue;
            if (isect_issue) idx_in = idx_ff + CW'(1);
            // stage 1: look up its bitmap bit
            bm_re    = p1_ff && c_ok;
            bm_raddr = kp_rdata_ff[AW-1:0];
            p2_in    = p1_ff;
            p2_c_in  = kp_rdata_ff;
            p2_ok_in = c_ok;
            // stage 2: compact survivors in place; write index never passes read index
            kp_wdata = p2_c_ff;
            if (p2_ff && p2_ok_ff && bm_rdata_ff) begin
               kp_we = 1'b1;
               n_in  = n_ff + CW'(1);
            end
            if (!isect_issue && !p1_ff && !p2_ff) begin
               count_in = n_ff;
               rp_in    = '0;
               res_in   = '{kind: cpdi_pkg::KIND_COUNT, element: '0,
                            kept_total: 13'(n_ff), last: 1'b0};
            end
         end
         cpdi_pkg::ST_RD_DATA: begin
            // advance read pointer, flag the final entry
            res_in = '{kind: cpdi_pkg::KIND_ELEMENT, element: kp_rdata_ff,
                       kept_total: '0, last: ((rp_ff + CW'(1)) == count_ff)};
            rp_in  = rp_ff + CW'(1);
         end
         cpdi_pkg::ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end
         default: ;
      endcase
   end

   // Configuration register decode
   always_comb begin
      column_select_in = column_select_ff;
      end_mode_in      = end_mode_ff;
      if (csr_fire) begin
         unique case (csr_index)
            cpdi_pkg::CSR_COLUMN_SELECT: column_select_in = csr_wdata;
            cpdi_pkg::CSR_END_MODE:      end_mode_in      = csr_wdata;
            default: ;
         endcase
      end
   end

   // Control registers; reset starts the bitmap clear pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= cpdi_pkg::ST_CLEAR;
         idx_ff           <= '0;
         n_ff             <= '0;
         count_ff         <= '0;
         rp_ff            <= '0;
         s1_ff            <= 1'b0;
         p1_ff            <= 1'b0;
         p2_ff            <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         column_select_ff <= 1'b0;
         end_mode_ff      <= 1'b0;
      end else begin
         state_ff         <= state_in;
         idx_ff           <= idx_in;
         n_ff             <= n_in;
         count_ff         <= count_in;
         rp_ff            <= rp_in;
         s1_ff            <= s1_in;
         p1_ff            <= p1_in;
         p2_ff            <= p2_in;
         rsp_valid_ff     <= rsp_valid_in;
         column_select_ff <= column_select_in;
         end_mode_ff      <= end_mode_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_addr_ff  <= s1_addr_in;
      p2_c_ff     <= p2_c_in;
      p2_ok_ff    <= p2_ok_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Seen bitmap memory
   always_ff @(posedge clock) begin
      if (bm_we) bitmap_mem[bm_waddr] <= bm_wdata;
      if (bm_re) bm_rdata_ff <= bitmap_mem[bm_raddr];
   end

   // Kept list memory
   always_ff @(posedge clock) begin
      if (kp_we) kept_mem[kp_waddr] <= kp_wdata;
      if (kp_re) kp_rdata_ff <= kept_mem[kp_raddr];
   end

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("kept count exceeds bitmap depth");

   a_rp_bound: assert property (@(posedge clock) disable iff (reset)
      rp_ff <= count_ff)
      else $error("read pointer beyond kept count");

   a_compact_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cpdi_pkg::ST_ISECT) |-> (n_ff <= idx_ff))
      else $error("intersect write index passed read index");

endmodule

>>> dv/projection_response_checker.sv
`timescale 1ns / 1ps
// Checker for the projection unit: predicts each response from observed requests and compares.
module projection_response_checker
   import cpdi_pkg::*;
#(
   parameter int MAX_IDS = 4096
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   input  logic    csr_valid,
   input  logic    csr_ready,
   input  logic [1:0] csr_index,
   input  logic    csr_wdata,
   output int      fail_count,
   output int      awaited_count
);

   // Shadow copy of the projection state and its registers
   bit          seen_ids [MAX_IDS];
   logic [11:0] kept_ids [MAX_IDS];
   int          kept_len;
   int          next_read;
   logic        column_sel;
   logic        intersect_mode;
   rsp_type     awaited_responses [$];

   // Advance the shadow state by one request; queue the response it owes
   function automatic void apply_projection_request(input req_type r);
      logic [11:0] id;
      int          n;
      rsp_type     resp;
      resp = '0;
      case (r.op)
         OP_BEGIN: begin
            foreach (seen_ids[v]) seen_ids[v] = 1'b0;
         end
         OP_EDGE: begin
            id = column_sel ? r.vertex_b : r.vertex_a;
            seen_ids[id] = 1'b1;
         end
         OP_END: begin
            n = 0;
            if (!intersect_mode) begin
               // rebuild from the bitmap, ascending
               for (int v = 0; v < MAX_IDS; v++) begin
                  if (seen_ids[v]) begin
                     kept_ids[n] = 12'(v);
                     n++;
                  end
               end
            end else begin
               // keep only entries still marked, in their order
               for (int i = 0; i < kept_len; i++) begin
                  if (seen_ids[kept_ids[i]]) begin
                     kept_ids[n] = kept_ids[i];
                     n++;
                  end
               end
            end
            kept_len = n;
            next_read = 0;
            resp.kind = KIND_COUNT;
            resp.kept_total = 13'(kept_len);
            awaited_responses.push_back(resp);
         end
         default: begin
            if (next_read < kept_len) begin
               resp.kind = KIND_ELEMENT;
               resp.element = kept_ids[next_read];
               resp.last = (next_read + 1 == kept_len);
               next_read++;
            end else begin
               resp.kind = KIND_EMPTY;
            end
            awaited_responses.push_back(resp);
         end
      endcase
   endfunction

   function automatic void compare_field(input string field, input logic [12:0] want_v,
                                         input logic [12:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want_v, got_v);
         fail_count++;
      end
   endfunction

   // Match a response against the oldest waiting one
   function automatic void check_response(input rsp_type got);
      rsp_type want;
      if (awaited_responses.size() == 0) begin
         $display("%0t: unexpected response: expected none, got kind=%0d element=%0d total=%0d last=%0d",
                  $time, got.kind, got.element, got.kept_total, got.last);
         fail_count++;
         return;
      end
      want = awaited_responses.pop_front();
      compare_field("kind", 13'(want.kind), 13'(got.kind));
      compare_field("element", 13'(want.element), 13'(got.element));
      compare_field("kept_total", want.kept_total, got.kept_total);
      compare_field("last", 13'(want.last), 13'(got.last));
   endfunction

   // Watch the three channels at each edge
   always @(posedge clock) begin
      if (reset) begin
         foreach (seen_ids[v]) seen_ids[v] = 1'b0;
         kept_len = 0;
         next_read = 0;
         column_sel = 1'b0;
         intersect_mode = 1'b0;
         awaited_responses.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_COLUMN_SELECT: column_sel = csr_wdata;
               CSR_END_MODE:      intersect_mode = csr_wdata;
               default:           ;
            endcase
         end
         if (req_valid && req_ready) apply_projection_request(req_data);
         if (rsp_valid && rsp_ready) check_response(rsp_data);
      end
      awaited_count <= awaited_responses.size();
   end

endmodule

>>> dv/column_projection_distinct_intersect_unit_test.sv
`timescale 1ns / 1ps
// Testbench top for the projection unit: stimulus, register writes, back-pressure and verdict.
module column_projection_distinct_intersect_unit_test;
   import cpdi_pkg::*;

   localparam int         MAX_IDS       = 4096;
   localparam int         HALF_PERIOD   = 6;
   localparam int         SETTLE_CYCLES = 4200;
   localparam int         RANDOM_ITEMS  = 600;
   localparam int         HOLD_CYCLES   = 400;
   localparam int         FILL_EDGES    = 64;
   localparam logic [1:0] CSR_SPARE_A   = 2'd2;
   localparam logic [1:0] CSR_SPARE_B   = 2'd3;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_ready;
   rsp_type    rsp_data;
   logic       csr_valid;
   logic       csr_ready;
   logic [1:0] csr_index;
   logic       csr_wdata;
   int         fail_count;
   int         awaited_count;
   int         items_sent;
   bit         quiet_stretch;
   bit         hold_off_armed;

   column_projection_distinct_intersect_unit #(
      .MAX_VERTICES(MAX_IDS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   projection_response_checker #(
      .MAX_IDS(MAX_IDS)
   ) response_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .fail_count(fail_count),
      .awaited_count(awaited_count)
   );

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   // Hard stop in case the block hangs
   initial begin
      #(30_000_000);
      $display("*** FAILED ***");
      $finish;
   end

   // Response back-pressure: random stalls, one long hold when armed
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_armed) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_armed = 1'b0;
         end
         rsp_ready <= quiet_stretch || ($urandom_range(99) >= 6);
      end
   end

   // Mostly small ids so relations overlap, with extremes and full-range values mixed in
   function automatic logic [11:0] pick_vertex();
      int roll;
      roll = $urandom_range(99);
      if (roll < 70) return 12'($urandom_range(15));
      if (roll < 80) return ($urandom_range(1) != 0) ? 12'hFFF : 12'h000;
      return 12'($urandom);
   endfunction

   // Offer one request, with an occasional gap ahead of it, and hold until accepted
   task automatic send_request(input op_type code, input logic [11:0] va,
                               input logic [11:0] vb);
      while (!quiet_stretch && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_data <= '{code, va, vb};
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic write_csr(input logic [1:0] index, input logic value);
      csr_index <= index;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Drain all responses, then let a trailing clear pass finish
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic col, input logic mode);
      wait_idle();
      write_csr(CSR_COLUMN_SELECT, col);
      write_csr(CSR_END_MODE, mode);
   endtask

   // One well-formed relation: begin, edges, end, then reads
   task automatic run_relation(input int edge_total, input int read_total, input bit choke);
      send_request(OP_BEGIN, pick_vertex(), pick_vertex());
      repeat (edge_total) send_request(OP_EDGE, pick_vertex(), pick_vertex());
      send_request(OP_END, pick_vertex(), pick_vertex());
      if (choke) hold_off_armed = 1'b1;
      repeat (read_total) send_request(OP_READ, pick_vertex(), pick_vertex());
   endtask

   initial begin
      int          phase_index;
      int          edge_total;
      logic        mode;
      logic [11:0] mask;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = CSR_COLUMN_SELECT;
      csr_wdata = 1'b0;
      quiet_stretch = 1'b0;
      hold_off_armed = 1'b0;
      items_sent = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Intersect on the empty list left by reset; reads on an empty list
      configure(1'b0, 1'b1);
      send_request(OP_READ, 12'h000, 12'h000);
      send_request(OP_END, 12'hFFF, 12'hFFF);
      send_request(OP_READ, 12'hFFF, 12'h000);

      // Replace with extreme ids and duplicates; read past the end
      configure(1'b0, 1'b0);
      send_request(OP_BEGIN, 12'h000, 12'h000);
      send_request(OP_EDGE, 12'h000, 12'hFFF);
      send_request(OP_EDGE, 12'hFFF, 12'h000);
      send_request(OP_EDGE, 12'hFFF, 12'h007);
      send_request(OP_EDGE, 12'h000, 12'h000);
      send_request(OP_END, 12'h000, 12'h000);
      repeat (3) send_request(OP_READ, 12'h000, 12'h000);

      // Second column, intersect; spare indexes must not disturb the registers
      configure(1'b1, 1'b1);
      write_csr(CSR_SPARE_A, 1'b0);
      write_csr(CSR_SPARE_B, 1'b0);
      send_request(OP_BEGIN, 12'h000, 12'h000);
      send_request(OP_EDGE, 12'h005, 12'hFFF);
      send_request(OP_EDGE, 12'h000, 12'h07B);
      send_request(OP_END, 12'h000, 12'h000);
      repeat (2) send_request(OP_READ, 12'h000, 12'h000);
      // begin leaves the kept list and read position alone
      send_request(OP_BEGIN, 12'h000, 12'h000);
      send_request(OP_READ, 12'h000, 12'h000);
      send_request(OP_END, 12'h000, 12'h000);
      send_request(OP_READ, 12'h000, 12'h000);

      // Random phases, each under its own register setting
      items_sent = 0;
      phase_index = 0;
      while (items_sent < RANDOM_ITEMS) begin
         quiet_stretch = (phase_index == 3 || phase_index == 4);
         if (phase_index == 6) mode = 1'b0;
         else if (phase_index == 7) mode = 1'b1;
         else mode = 1'($urandom_range(1));
         configure(1'($urandom_range(1)), mode);
         if (phase_index == 6) begin
            // mark ids spread over the whole range in scrambled order for a long kept list
            mask = 12'($urandom);
            send_request(OP_BEGIN, 12'h000, 12'h000);
            for (int i = 0; i < FILL_EDGES; i++) begin
               send_request(OP_EDGE, 12'(i * 64) ^ mask, 12'(i * 64) ^ mask);
            end
            send_request(OP_END, 12'h000, 12'h000);
            repeat (3) send_request(OP_READ, pick_vertex(), pick_vertex());
         end
         repeat ($urandom_range(1, 2)) begin
            if ($urandom_range(99) < 85) begin
               edge_total = $urandom_range(1, 24);
               if (phase_index == 2) begin
                  run_relation(edge_total, 40, 1'b1);
               end else begin
                  run_relation(edge_total, $urandom_range(0, edge_total + 3), 1'b0);
               end
            end else begin
               // noise: any request in any order, full-range ids
               repeat ($urandom_range(4, 10)) begin
                  send_request(op_type'($urandom_range(3)), 12'($urandom), 12'($urandom));
               end
            end
         end
         phase_index++;
      end

      wait_idle();
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/cpdi_pkg.sv
hw/rtl/column_projection_distinct_intersect_unit.sv
dv/projection_response_checker.sv
dv/column_projection_distinct_intersect_unit_test.sv
